// File: sv/lhc_pkg.sv
`default_nettype none

package lhc_pkg;

   localparam int KEY_W    = 64;
   localparam int HANDLE_W = 16;
   localparam int MODE_W   = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EVICT  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [HANDLE_W-1:0] file_handle;
      logic [KEY_W-1:0]    key;
   } req_type;

   typedef struct packed {
      logic                handle_valid;
      logic [HANDLE_W-1:0] handle_out;
      logic [KEY_W-1:0]    key_out;
      logic                stored;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_LINK,
      ST_INS_HEAD,
      ST_INS_BKT,
      ST_RM_WAIT,
      ST_RM_BKT,
      ST_UNLINK,
      ST_EV_WAIT,
      ST_EV_BKT,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// File: sv/lhc_ram.sv
`default_nettype none

module lhc_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Single write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: sv/lhc_bucket_mod.sv
`default_nettype none

module lhc_bucket_mod #(
   parameter int BUCKETS = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [lhc_pkg::KEY_W-1:0]  key,
   output      logic                       done,
   output      logic [$clog2(BUCKETS)-1:0] bucket
);
   import lhc_pkg::*;

   localparam int  BW   = $clog2(BUCKETS);
   localparam bit  POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

   generate
      if (POW2) begin : g_mask
         logic          done_ff;
         logic [BW-1:0] rem_ff;

         // A power-of-two bucket count is a plain mask of the low key bits.
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else if (start) begin
               done_ff <= 1'b1;
            end
            if (start) begin
               rem_ff <= key[BW-1:0];
            end
         end

         assign done   = done_ff;
         assign bucket = rem_ff;
      end else begin : g_recip
         localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));

         logic              done_ff, done_in;
         logic [3:0]        cnt_ff, cnt_in;
         logic [KEY_W-1:0]  key_ff, key_in;
         logic [BW-1:0]     rem_ff, rem_in;
         logic [31:0]       part_ff, part_in;
         logic [31:0]       quot_ff, quot_in;
         logic [31:0]       part_next;
         logic [63:0]       prod;
         logic [47:0]       quot_bkt;
         logic [31:0]       diff;

         // Reduction 16 key bits at a time from the top down; for each digit
         // a reciprocal multiply estimates the quotient, then one subtraction fixes it.
         always_comb begin
            part_next = {16'(rem_ff), key_ff[KEY_W-1 -: 16]};
            prod      = {32'd0, part_next} * {32'd0, RECIP};
            quot_bkt  = {16'd0, quot_ff} * 48'(BUCKETS);
            diff      = part_ff - quot_bkt[31:0];
            done_in   = done_ff;
            cnt_in    = cnt_ff;
            key_in    = key_ff;
            rem_in    = rem_ff;
            part_in   = part_ff;
            quot_in   = quot_ff;
            if (start) begin
               done_in = 1'b0;
               cnt_in  = 4'd8;
               key_in  = key;
               rem_in  = '0;
            end else if (cnt_ff != '0) begin
               if (!cnt_ff[0]) begin
                  part_in = part_next;
                  quot_in = prod[63:32];
                  key_in  = {key_ff[KEY_W-17:0], 16'd0};
               end else begin
                  // The estimate is short by at most one, so one subtraction is enough.
                  if (diff >= 32'(BUCKETS)) begin
                     rem_in = BW'(diff - 32'(BUCKETS));
                  end else begin
                     rem_in = diff[BW-1:0];
                  end
                  if (cnt_ff == 4'd1) begin
                     done_in = 1'b1;
                  end
               end
               cnt_in = cnt_ff - 4'd1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
               cnt_ff  <= '0;
            end else begin
               done_ff <= done_in;
               cnt_ff  <= cnt_in;
            end
            key_ff  <= key_in;
            rem_ff  <= rem_in;
            part_ff <= part_in;
            quot_ff <= quot_in;
         end

         assign done   = done_ff;
         assign bucket = rem_ff;
      end
   endgenerate

endmodule

`default_nettype wire

// File: sv/lru_handle_cache_direct_mapped.sv
`default_nettype none

// Recency cache of 16-bit handles keyed by 64-bit keys, with a direct-mapped
// bucket index (key modulo BUCKETS). Entries, links, the bucket table and the
// free stack live in single-port-write synchronous RAMs, and a sequencer walks
// each request through them one access step at a time, one request at a time.
// The response word follows the chain of dependent RAM reads: a dropped insert,
// an empty evict or an unknown mode goes straight to the response; a remove reads
// its bucket and, on a key match, unlinks the entry and clears the bucket; an
// insert links the new entry at the head, points its bucket at it and unlinks
// any entry that it displaces; an evict unlinks the tail and clears its bucket
// if it still points there. The next request is taken in the cycle after the
// word is loaded, and a response word that is held off keeps the sequencer
// waiting. With a bucket count that is not a power of two, the sequencer waits
// for a sequential key-to-bucket reduction. After reset the bucket table is swept
// to empty, one entry a cycle, and requests are stalled until the sweep ends.
module lru_handle_cache_direct_mapped #(
   parameter int ENTRIES = 1024,
   parameter int BUCKETS = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire lhc_pkg::req_type req_word,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      lhc_pkg::rsp_type rsp_word
);
   import lhc_pkg::*;

   localparam int SW = $clog2(ENTRIES);
   localparam int IW = $clog2(ENTRIES + 1);
   localparam int BW = $clog2(BUCKETS);
   localparam int EW = $bits(entry_type);
   localparam logic [IW-1:0] NULL_IDX = IW'(ENTRIES);

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   logic [IW-1:0] count_ff, count_in;
   logic [IW-1:0] minc_ff, minc_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [IW-1:0] vict_ff, vict_in;
   logic [IW-1:0] oldh_ff, oldh_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic          fresh_ff, fresh_in;
   logic          clear_busy_ff;
   logic [BW-1:0] clear_idx_ff;

   // Memory ports.
   logic          ent_we, ent_re;
   logic [SW-1:0] ent_wa, ent_ra;
   entry_type     ent_wd, ent_rd;
   logic          prv_we, prv_re, nxt_we, nxt_re;
   logic [SW-1:0] prv_wa, prv_ra, nxt_wa, nxt_ra;
   logic [IW-1:0] prv_wd, prv_rd, nxt_wd, nxt_rd;
   logic          stk_we, stk_re;
   logic [SW-1:0] stk_wa, stk_ra, stk_wd, stk_rd;
   logic          bkt_we, bkt_re, seq_bkt_we;
   logic [BW-1:0] bkt_wa, bkt_ra, seq_bkt_wa;
   logic [IW-1:0] bkt_wd, bkt_rd, seq_bkt_wd;

   logic          mod_start, mod_done;
   logic [KEY_W-1:0] mod_key;
   logic [BW-1:0] mod_bucket;

   logic          accept, rsp_free, hit;
   logic [IW-1:0] new_slot, pop_pos;

   lhc_ram #(.DEPTH(ENTRIES), .WIDTH(EW)) u_ent (
      .clock, .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(ent_wd),
      .rd_en(ent_re), .rd_addr(ent_ra), .rd_data(ent_rd)
   );
   lhc_ram #(.DEPTH(ENTRIES), .WIDTH(IW)) u_prev (
      .clock, .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_en(prv_re), .rd_addr(prv_ra), .rd_data(prv_rd)
   );
   lhc_ram #(.DEPTH(ENTRIES), .WIDTH(IW)) u_next (
      .clock, .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_en(nxt_re), .rd_addr(nxt_ra), .rd_data(nxt_rd)
   );
   lhc_ram #(.DEPTH(ENTRIES), .WIDTH(SW)) u_stack (
      .clock, .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_en(stk_re), .rd_addr(stk_ra), .rd_data(stk_rd)
   );
   lhc_ram #(.DEPTH(BUCKETS), .WIDTH(IW)) u_bkt (
      .clock, .wr_en(bkt_we), .wr_addr(bkt_wa), .wr_data(bkt_wd),
      .rd_en(bkt_re), .rd_addr(bkt_ra), .rd_data(bkt_rd)
   );

   lhc_bucket_mod #(.BUCKETS(BUCKETS)) u_mod (
      .clock, .reset, .start(mod_start), .key(mod_key),
      .done(mod_done), .bucket(mod_bucket)
   );

   assign req_stall = (state_ff != ST_IDLE) || clear_busy_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Slot popped from the free stack: never-pushed positions map to a slot computed in reset order.
   assign pop_pos  = count_ff - IW'(1);
   assign new_slot = fresh_ff ? (IW'(ENTRIES - 1) - IW'(pos_ff)) : IW'(stk_rd);
   assign hit      = (req_ff.mode != MODE_REMOVE) || (ent_rd.key == req_ff.key);

   // Bucket table writes come from the clearing sweep or from the sequencer.
   assign bkt_we = clear_busy_ff || seq_bkt_we;
   assign bkt_wa = clear_busy_ff ? clear_idx_ff : seq_bkt_wa;
   assign bkt_wd = clear_busy_ff ? NULL_IDX : seq_bkt_wd;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_word.mode)
                  MODE_INSERT: state_in = (count_ff == '0) ? ST_RESP : ST_INS_LINK;
                  MODE_REMOVE: state_in = ST_RM_WAIT;
                  MODE_EVICT:  state_in = (tail_ff == NULL_IDX) ? ST_RESP : ST_UNLINK;
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_INS_LINK: state_in = ST_INS_HEAD;
         ST_INS_HEAD: if (mod_done) state_in = ST_INS_BKT;
         ST_INS_BKT: begin
            if (bkt_rd != NULL_IDX && bkt_rd != slot_ff) state_in = ST_UNLINK;
            else state_in = ST_RESP;
         end
         ST_RM_WAIT: if (mod_done) state_in = ST_RM_BKT;
         ST_RM_BKT:  state_in = (bkt_rd != NULL_IDX) ? ST_UNLINK : ST_RESP;
         ST_UNLINK: begin
            if (hit && req_ff.mode == MODE_EVICT) state_in = ST_EV_WAIT;
            else state_in = ST_RESP;
         end
         ST_EV_WAIT: if (mod_done) state_in = ST_EV_BKT;
         ST_EV_BKT:  state_in = ST_RESP;
         ST_RESP:    if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Memory controls and datapath updates.
   always_comb begin
      req_in   = req_ff;
      res_in   = res_ff;
      count_in = count_ff;
      minc_in  = minc_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      slot_in  = slot_ff;
      vict_in  = vict_ff;
      oldh_in  = oldh_ff;
      pos_in   = pos_ff;
      fresh_in = fresh_ff;
      ent_we = 1'b0; ent_wa = '0; ent_wd = '0; ent_re = 1'b0; ent_ra = '0;
      prv_we = 1'b0; prv_wa = '0; prv_wd = '0; prv_re = 1'b0; prv_ra = '0;
      nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_re = 1'b0; nxt_ra = '0;
      stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_re = 1'b0; stk_ra = '0;
      seq_bkt_we = 1'b0; seq_bkt_wa = '0; seq_bkt_wd = '0; bkt_re = 1'b0; bkt_ra = '0;
      mod_start = 1'b0;
      mod_key   = req_word.key;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_word;
               res_in = '0;
               case (req_word.mode)
                  MODE_INSERT: begin
                     mod_start = 1'b1;
                     if (count_ff != '0) begin
                        // Pop the free stack.
                        stk_re   = 1'b1;
                        stk_ra   = pop_pos[SW-1:0];
                        pos_in   = pop_pos[SW-1:0];
                        count_in = pop_pos;
                        fresh_in = pop_pos < minc_ff;
                        if (pop_pos < minc_ff) minc_in = pop_pos;
                     end
                  end
                  MODE_REMOVE: mod_start = 1'b1;
                  MODE_EVICT: begin
                     if (tail_ff != NULL_IDX) begin
                        vict_in = tail_ff;
                        ent_re = 1'b1; ent_ra = tail_ff[SW-1:0];
                        prv_re = 1'b1; prv_ra = tail_ff[SW-1:0];
                        nxt_re = 1'b1; nxt_ra = tail_ff[SW-1:0];
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_INS_LINK: begin
            // Write the new entry and link it in front of the old head.
            slot_in = new_slot;
            ent_we = 1'b1; ent_wa = new_slot[SW-1:0];
            ent_wd = '{key: req_ff.key, handle: req_ff.file_handle};
            nxt_we = 1'b1; nxt_wa = new_slot[SW-1:0]; nxt_wd = head_ff;
            prv_we = 1'b1; prv_wa = new_slot[SW-1:0]; prv_wd = NULL_IDX;
            oldh_in = head_ff;
            head_in = new_slot;
            if (tail_ff == NULL_IDX) tail_in = new_slot;
         end
         ST_INS_HEAD: begin
            if (oldh_ff != NULL_IDX) begin
               prv_we = 1'b1; prv_wa = oldh_ff[SW-1:0]; prv_wd = slot_ff;
            end
            if (mod_done) begin
               bkt_re = 1'b1; bkt_ra = mod_bucket;
            end
         end
         ST_INS_BKT: begin
            // The bucket now maps to the new slot; a previous occupant is displaced.
            seq_bkt_we = 1'b1; seq_bkt_wa = mod_bucket; seq_bkt_wd = slot_ff;
            res_in.stored = 1'b1;
            if (bkt_rd != NULL_IDX && bkt_rd != slot_ff) begin
               vict_in = bkt_rd;
               ent_re = 1'b1; ent_ra = bkt_rd[SW-1:0];
               prv_re = 1'b1; prv_ra = bkt_rd[SW-1:0];
               nxt_re = 1'b1; nxt_ra = bkt_rd[SW-1:0];
            end
         end
         ST_RM_WAIT: begin
            if (mod_done) begin
               bkt_re = 1'b1; bkt_ra = mod_bucket;
            end
         end
         ST_RM_BKT: begin
            if (bkt_rd != NULL_IDX) begin
               vict_in = bkt_rd;
               ent_re = 1'b1; ent_ra = bkt_rd[SW-1:0];
               prv_re = 1'b1; prv_ra = bkt_rd[SW-1:0];
               nxt_re = 1'b1; nxt_ra = bkt_rd[SW-1:0];
            end
         end
         ST_UNLINK: begin
            // Unlink a hit victim, fix head and tail, push it on the free stack and, for a remove, clear its bucket.
            if (hit) begin
               res_in.handle_valid = 1'b1;
               res_in.handle_out   = ent_rd.handle;
               res_in.key_out      = ent_rd.key;
               if (prv_rd != NULL_IDX) begin
                  nxt_we = 1'b1; nxt_wa = prv_rd[SW-1:0]; nxt_wd = nxt_rd;
               end
               if (nxt_rd != NULL_IDX) begin
                  prv_we = 1'b1; prv_wa = nxt_rd[SW-1:0]; prv_wd = prv_rd;
               end
               if (vict_ff == head_ff) head_in = nxt_rd;
               if (vict_ff == tail_ff) tail_in = prv_rd;
               if (count_ff < IW'(ENTRIES)) begin
                  stk_we = 1'b1; stk_wa = count_ff[SW-1:0]; stk_wd = vict_ff[SW-1:0];
                  count_in = count_ff + IW'(1);
               end
               if (req_ff.mode == MODE_REMOVE) begin
                  seq_bkt_we = 1'b1; seq_bkt_wa = mod_bucket; seq_bkt_wd = NULL_IDX;
               end
               if (req_ff.mode == MODE_EVICT) begin
                  mod_start = 1'b1;
                  mod_key   = ent_rd.key;
               end
            end
         end
         ST_EV_WAIT: begin
            if (mod_done) begin
               bkt_re = 1'b1; bkt_ra = mod_bucket;
            end
         end
         ST_EV_BKT: begin
            if (bkt_rd == vict_ff) begin
               seq_bkt_we = 1'b1; seq_bkt_wa = mod_bucket; seq_bkt_wd = NULL_IDX;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= IW'(ENTRIES);
         minc_ff       <= IW'(ENTRIES);
         head_ff       <= NULL_IDX;
         tail_ff       <= NULL_IDX;
         rsp_valid_ff  <= 1'b0;
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         minc_ff  <= minc_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         // Empty the bucket table after reset.
         if (clear_busy_ff) begin
            clear_idx_ff <= clear_idx_ff + BW'(1);
            if (clear_idx_ff == BW'(BUCKETS - 1)) clear_busy_ff <= 1'b0;
         end
         // Output register: a taken word frees it, a finished request fills it.
         if (state_ff == ST_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      req_ff   <= req_in;
      res_ff   <= res_in;
      slot_ff  <= slot_in;
      vict_ff  <= vict_in;
      oldh_ff  <= oldh_in;
      pos_ff   <= pos_in;
      fresh_ff <= fresh_in;
      if (state_ff == ST_RESP && rsp_free) rsp_ff <= res_ff;
   end

endmodule

`default_nettype wire
